/* design/scb_pkg.sv */
`default_nettype none
package scb_pkg;

	localparam int unsigned APEX_W = 32;
	localparam int unsigned ROT_W  = 16;
	localparam int unsigned COS_W  = 16;
	localparam int unsigned RANGE_W = 31;
	localparam int unsigned H_W    = 46;
	localparam int unsigned H_LO_W = 23;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CONE_COSINE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONE_RANGE  = 8'd1;

	localparam logic [COS_W-1:0]   COS_RESET   = 16'd23170;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 31'd655360;
	localparam logic [COS_W-1:0]   COS_ONE     = 16'd32768;

	// apex[0..2] in the low bits, then rot[r*3+k]
	typedef struct packed {
		logic [8:0][ROT_W-1:0]  rot;
		logic [2:0][APEX_W-1:0] apex;
	} pose_t;

	// edge[axis*2] is the minimum, edge[axis*2+1] the maximum
	typedef logic [5:0][APEX_W-1:0] box_t;

	typedef struct packed {
		logic               busy;
		logic [H_W-1:0]     h;
		logic [RANGE_W-1:0] range;
	} cone_t;

endpackage
`default_nettype wire

/* design/scb_hcalc.sv */
`default_nettype none
module scb_hcalc
	import scb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cone_t                      cone
);

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_SQRT = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t             state_q;
	logic [COS_W-1:0]   cos_q;
	logic [RANGE_W-1:0] range_q;
	logic [COS_W-1:0]   div_q;
	logic [31:0]        x_q;
	logic [31:0]        res_q;
	logic [31:0]        bit_q;
	logic [H_W-1:0]     num_q;
	logic [COS_W-1:0]   rem_q;
	logic [5:0]         cnt_q;

	logic [COS_W-1:0] cos_clamp;
	logic [31:0]      cos_sq;
	logic [31:0]      trial_sqrt;
	logic [COS_W:0]   trial_div;

	always_comb begin
		if (cos_q == '0) begin
			cos_clamp = COS_W'(1);
		end else if (cos_q > COS_ONE) begin
			cos_clamp = COS_ONE;
		end else begin
			cos_clamp = cos_q;
		end
		cos_sq     = 32'(cos_clamp) * 32'(cos_clamp);
		trial_sqrt = res_q + bit_q;
		trial_div  = {rem_q, num_q[H_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cos_q   <= COS_RESET;
			range_q <= RANGE_RESET;
		end else if (wr_en && (wr_index == REG_CONE_COSINE || wr_index == REG_CONE_RANGE)) begin
			if (wr_index == REG_CONE_COSINE) begin
				cos_q <= wr_data[COS_W-1:0];
			end else begin
				range_q <= wr_data[RANGE_W-1:0];
			end
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: state_q <= ST_SQRT;
				ST_SQRT: if (cnt_q == 6'd1) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  if (cnt_q == 6'd1) state_q <= ST_DONE;
				ST_DONE: state_q <= ST_DONE;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// digit-by-digit root, multiply by the range, then restoring divide by the clamped cosine
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				div_q <= cos_clamp;
				x_q   <= 32'h4000_0000 - cos_sq;
				res_q <= '0;
				bit_q <= 32'h4000_0000;
				cnt_q <= 6'd16;
			end
			ST_SQRT: begin
				if (x_q >= trial_sqrt) begin
					x_q   <= x_q - trial_sqrt;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 6'd1;
			end
			ST_MUL: begin
				num_q <= H_W'(range_q) * H_W'(res_q[COS_W-1:0]);
				rem_q <= '0;
				cnt_q <= 6'(H_W);
			end
			ST_DIV: begin
				if (trial_div >= {1'b0, div_q}) begin
					rem_q <= COS_W'(trial_div - {1'b0, div_q});
					num_q <= {num_q[H_W-2:0], 1'b1};
				end else begin
					rem_q <= trial_div[COS_W-1:0];
					num_q <= {num_q[H_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign cone.busy  = (state_q != ST_DONE);
	assign cone.h     = num_q;
	assign cone.range = range_q;

endmodule
`default_nettype wire

/* design/scb_fifo.sv */
`default_nettype none
module scb_fifo
	import scb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire pose_t push_data,
	output logic       full,
	input  wire logic  pop,
	output logic       pop_valid,
	output pose_t      pop_data
);

	pose_t      mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign full      = (count_q == 2'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

/* design/scb_box.sv */
`default_nettype none
module scb_box
	import scb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cone_t cone,
	input  wire logic  in_valid,
	input  wire pose_t in_pose,
	output logic       in_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output box_t       out_box
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;

	logic signed [31:0] apex_s1 [3], apex_s2 [3], apex_s3 [3];
	logic signed [47:0] cm_s1 [3];
	logic signed [39:0] r_lo_s1 [3], r_hi_s1 [3], u_lo_s1 [3], u_hi_s1 [3];
	logic signed [63:0] ctr_s2 [3], rt_s2 [3], up_s2 [3];
	logic signed [63:0] pt_s3 [3][4];
	logic signed [63:0] lo_a_s4 [3], lo_b_s4 [3], hi_a_s4 [3], hi_b_s4 [3];
	logic signed [31:0] apex_s4 [3];
	box_t               box_q;

	logic signed [23:0] h_lo, h_hi;
	logic signed [31:0] rng;

	assign en     = !out_valid_q || out_ready;
	assign in_pop = en && in_valid;
	assign h_lo   = $signed({1'b0, cone.h[H_LO_W-1:0]});
	assign h_hi   = $signed({1'b0, cone.h[H_W-1:H_LO_W]});
	assign rng    = $signed({1'b0, cone.range});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	function automatic logic signed [63:0] smin(logic signed [63:0] a, logic signed [63:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [63:0] smax(logic signed [63:0] a, logic signed [63:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [31:0] sat(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				// products; h is split in halves to keep each multiplier narrow
				apex_s1[a] <= $signed(in_pose.apex[a]);
				cm_s1[a]   <= rng * $signed(in_pose.rot[a*3+2]);
				r_lo_s1[a] <= h_lo * $signed(in_pose.rot[a*3]);
				r_hi_s1[a] <= h_hi * $signed(in_pose.rot[a*3]);
				u_lo_s1[a] <= h_lo * $signed(in_pose.rot[a*3+1]);
				u_hi_s1[a] <= h_hi * $signed(in_pose.rot[a*3+1]);

				apex_s2[a] <= apex_s1[a];
				ctr_s2[a]  <= (64'(apex_s1[a]) <<< 14) - 64'(cm_s1[a]);
				rt_s2[a]   <= (64'(r_hi_s1[a]) <<< H_LO_W) + 64'(r_lo_s1[a]);
				up_s2[a]   <= (64'(u_hi_s1[a]) <<< H_LO_W) + 64'(u_lo_s1[a]);

				// arithmetic shift rounds toward minus infinity
				apex_s3[a]  <= apex_s2[a];
				pt_s3[a][0] <= (ctr_s2[a] + rt_s2[a] + up_s2[a]) >>> 14;
				pt_s3[a][1] <= (ctr_s2[a] - rt_s2[a] + up_s2[a]) >>> 14;
				pt_s3[a][2] <= (ctr_s2[a] + rt_s2[a] - up_s2[a]) >>> 14;
				pt_s3[a][3] <= (ctr_s2[a] - rt_s2[a] - up_s2[a]) >>> 14;

				apex_s4[a] <= apex_s3[a];
				lo_a_s4[a] <= smin(pt_s3[a][0], pt_s3[a][1]);
				lo_b_s4[a] <= smin(pt_s3[a][2], pt_s3[a][3]);
				hi_a_s4[a] <= smax(pt_s3[a][0], pt_s3[a][1]);
				hi_b_s4[a] <= smax(pt_s3[a][2], pt_s3[a][3]);

				box_q[a*2]   <= sat(smin(smin(lo_a_s4[a], lo_b_s4[a]), 64'(apex_s4[a])));
				box_q[a*2+1] <= sat(smax(smax(hi_a_s4[a], hi_b_s4[a]), 64'(apex_s4[a])));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_box   = box_q;

endmodule
`default_nettype wire

/* design/spot_cone_bounding_box.sv */
// Spot-light cone bounding box.
// s_* takes one light pose per transaction: s_tdata holds apex x, y, z
// (signed Q16.16) from bit 0, then the nine rotation entries row by row
// (signed Q2.14). m_* returns the box: min x, max x, min y, max y,
// min z, max z, each signed Q16.16 and saturated.
// cfg_* writes cone_cosine (index 0) and cone_range (index 1); write only
// while the block is empty. Each write to either register starts a
// recompute of the far-plane half-width (one load step, 16 root steps,
// one multiply step and 46 divide steps); s_tready stays low meanwhile.
// After reset the same recompute runs with the reset register values.
// Throughput is one pose per cycle unless a recompute runs or the output
// stalls. Poses pass the input queue and five pipeline stages to m_tvalid.
// While m_tvalid is high and m_tready low the pipeline holds; the two-entry
// input queue keeps taking poses until full, then s_tready drops.
`default_nettype none
module spot_cone_bounding_box
	import scb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// apex_x, apex_y, apex_z, rot_r0_c0 .. rot_r2_c2
	input  wire logic [239:0]          s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z
	output logic [191:0]               m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cone_t cone;
	logic  q_full, q_pop, q_valid;
	pose_t q_pose;
	box_t  box;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full && !cone.busy && !cfg_valid;

	scb_hcalc u_hcalc (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cone     (cone)
	);

	scb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_data (pose_t'(s_tdata)),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_pose)
	);

	scb_box u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.cone      (cone),
		.in_valid  (q_valid),
		.in_pose   (q_pose),
		.in_pop    (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_box   (box)
	);

	assign m_tdata = box;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cone.busy |-> !s_tready) else $error("pose accepted during recompute");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_CONE_COSINE || cfg_index == REG_CONE_RANGE)
		|=> cone.busy) else $error("config write did not restart recompute");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(box[0]) <= $signed(box[1])) && ($signed(box[2]) <= $signed(box[3]))
		&& ($signed(box[4]) <= $signed(box[5]))) else $error("box minimum above maximum");

endmodule
`default_nettype wire
